// ===== rtl/pavp_pkg.sv =====
// Shared constants and types for the average-predictor residual block.
package pavp_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int PIX_W  = 8;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 1;

	localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd1024;

	typedef struct packed {
		logic col_nz;
		logic row_nz;
		logic frame_last;
	} pos_t;

endpackage

// ===== rtl/pavp_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
module pavp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pavp_ctrl.sv =====
// Configuration registers and column and row position counters.
module pavp_ctrl import pavp_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CIDX_W-1:0]            cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         fire,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output pos_t                         pos
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LWW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
	localparam int LWH = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;

	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [LWW-1:0]  w_eff;
	logic [LWH-1:0]  h_eff;
	logic [LWW-1:0]  fw_ext;
	logic [LWH-1:0]  fh_ext;
	logic            col_last;
	logic            row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[FH_W-1:0];
				default:          ;
			endcase
		end
	end

	// Zero counts as one and anything above the maximum saturates.
	always_comb begin
		fw_ext = LWW'(fw_q);
		fh_ext = LWH'(fh_q);
		if (fw_q == '0) begin
			w_eff = LWW'(1);
		end else if (fw_ext > LWW'(MAX_WIDTH)) begin
			w_eff = LWW'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		if (fh_q == '0) begin
			h_eff = LWH'(1);
		end else if (fh_ext > LWH'(MAX_HEIGHT)) begin
			h_eff = LWH'(MAX_HEIGHT);
		end else begin
			h_eff = fh_ext;
		end
	end

	assign col_last = (LWW'(col_q) + LWW'(1)) >= w_eff;
	assign row_last = (LWH'(row_q) + LWH'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign col            = col_q;
	assign pos.col_nz     = (col_q != '0);
	assign pos.row_nz     = (row_q != '0);
	assign pos.frame_last = col_last && row_last;

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < MAX_WIDTH)
		else $error("column counter beyond line store depth");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) < MAX_HEIGHT)
		else $error("row counter beyond maximum height");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pos.frame_last |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap after last pixel of frame");

endmodule

// ===== rtl/pavp_pred.sv =====
// Prediction and residual stage with left-pixel register and output register.
module pavp_pred import pavp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [PIX_W-1:0] pixel,
	input  pos_t             pos,
	input  logic [PIX_W-1:0] above,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] residual,
	output logic             frame_last
);

	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [PIX_W-1:0] left_s1;
	pos_t             pos_s1;
	logic [PIX_W-1:0] left_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] residual_q;
	logic             last_q;
	logic             adv_s1;
	logic [PIX_W:0]   sum;
	logic [PIX_W-1:0] pred;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_s1 <= 1'b1;
				left_q   <= pixel;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pixel_s1 <= pixel;
			left_s1  <= left_q;
			pos_s1   <= pos;
		end
		if (adv_s1) begin
			residual_q <= pixel_s1 - pred;
			last_q     <= pos_s1.frame_last;
		end
	end

	assign sum = {1'b0, above} + {1'b0, left_s1};

	always_comb begin
		priority if (pos_s1.row_nz && pos_s1.col_nz) begin
			pred = sum[PIX_W:1];
		end else if (pos_s1.row_nz) begin
			pred = above;
		end else if (pos_s1.col_nz) begin
			pred = left_s1;
		end else begin
			pred = '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign residual   = residual_q;
	assign frame_last = last_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("stage one item lost while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("output item dropped before transfer");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input not ready while stage one is empty");

endmodule

// ===== rtl/pixel_average_predictor_diff_top.sv =====
// Top level of the average-predictor pixel residual block.
// Pipeline: a transferred pixel is captured in the stage-one registers together with the
// line store read, and its residual is registered at the output when stage one advances.
// Throughput: one pixel per cycle while m_tready does not stall the output; the line store
// is read and written once per pixel at the same address, so no forwarding is needed.
// Reset: asynchronous, active low; counters, left pixel and valids clear, width and
// height return to 1024, and the line store contents stay undefined until written.
module pixel_average_predictor_diff_top import pavp_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] pixel
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] residual
	output logic              m_tlast,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic             fire;
	logic [CW-1:0]    col;
	pos_t             pos;
	logic [PIX_W-1:0] above;

	assign fire = s_tvalid && s_tready;

	pavp_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.col       (col),
		.pos       (pos)
	);

	pavp_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (fire),
		.waddr (col),
		.wdata (s_tdata),
		.re    (fire),
		.raddr (col),
		.rdata (above)
	);

	pavp_pred u_pred (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.pixel      (s_tdata),
		.pos        (pos),
		.above      (above),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.residual   (m_tdata),
		.frame_last (m_tlast)
	);

endmodule
